/* hw/rtl/tose_pkg.sv */
// Package: shared types, opcodes and constants of the typed operand stack executor.
`default_nettype none
package tose_pkg;
	localparam int STACK_DEPTH = 1024;
	localparam int LOCAL_COUNT = 32;
	localparam int SP_W = $clog2(STACK_DEPTH);
	localparam int LI_W = $clog2(LOCAL_COUNT);

	localparam logic [3:0] OP_IPUSH = 4'd0;
	localparam logic [3:0] OP_DPUSH = 4'd1;
	localparam logic [3:0] OP_LOAD  = 4'd2;
	localparam logic [3:0] OP_STORE = 4'd3;
	localparam logic [3:0] OP_I2D   = 4'd4;
	localparam logic [3:0] OP_DMUL  = 4'd5;
	localparam logic [3:0] OP_IINC  = 4'd6;
	localparam logic [3:0] OP_ASTORE = 4'd7;
	localparam logic [3:0] OP_CMPGE = 4'd8;
	localparam logic [3:0] OP_CMPGT = 4'd9;

	localparam logic [1:0] KIND_DONE = 2'd0;
	localparam logic [1:0] KIND_CMP  = 2'd1;
	localparam logic [1:0] KIND_WR   = 2'd2;

	localparam logic [1:0] TAG_INT = 2'd0;
	localparam logic [1:0] TAG_DBL = 2'd2;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [4:0]  local_index;
		logic [63:0] immediate;
	} req_t;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic               branch_taken;
		logic [63:0]        write_reference;
		logic signed [31:0] write_index;
		logic [63:0]        write_data;
		logic               stack_fault;
	} rsp_t;
endpackage
`default_nettype wire

/* hw/rtl/tose_fpu.sv */
// Multi-cycle double multiply and int-to-double conversion unit.
`default_nettype none
module tose_fpu import tose_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic        is_mul,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      res
);
	typedef enum logic [5:0] {
		F_IDLE = 6'b000001, F_MUL = 6'b000010, F_NORM = 6'b000100,
		F_RND = 6'b001000, F_CVT = 6'b010000, F_OUT = 6'b100000
	} fst_t;
	fst_t st_q;
	logic        sgn_q;
	logic signed [13:0] exp_q;
	logic [52:0] ma_q, mb_q;
	logic [105:0] acc_q;
	logic [5:0]  cnt_q;
	logic        spc_q;
	logic [63:0] spc_val_q;
	logic [63:0] res_q;

	logic [10:0] ea, eb;
	logic [51:0] fa, fb;
	logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [52:0] na, nb;
	logic signed [13:0] xa, xb;
	logic [31:0] iv, imag;
	logic [105:0] part;
	always_comb begin
		ea = a[62:52]; eb = b[62:52]; fa = a[51:0]; fb = b[51:0];
		a_nan = (ea == 11'h7ff) && (fa != '0);
		b_nan = (eb == 11'h7ff) && (fb != '0);
		a_inf = (ea == 11'h7ff) && (fa == '0);
		b_inf = (eb == 11'h7ff) && (fb == '0);
		a_zero = (ea == '0) && (fa == '0);
		b_zero = (eb == '0) && (fb == '0);
		na = {(ea != '0), fa};
		nb = {(eb != '0), fb};
		xa = (ea == '0) ? 14'sd1 : $signed({3'b000, ea});
		xb = (eb == '0) ? 14'sd1 : $signed({3'b000, eb});
		iv = a[31:0];
		imag = iv[31] ? (~iv + 32'd1) : iv;
		part = mb_q[0] ? {53'd0, ma_q} : '0;
	end

	// Rounding of the normalised product or integer in acc_q (leading one at bit 105 or lower).
	logic [52:0] mant;
	logic        gbit, sticky, rup;
	logic [53:0] mr;
	logic signed [13:0] er;
	logic [63:0] packed_r;
	logic [5:0]  sh;
	logic [105:0] shv;
	logic signed [13:0] eb0;
	always_comb begin
		// Subnormal result: shift right so the exponent reaches 1.
		sh = '0;
		eb0 = exp_q;
		if (exp_q < 14'sd1) begin
			sh = (exp_q < -14'sd60) ? 6'd60 : 6'(14'sd1 - exp_q);
			eb0 = 14'sd1;
		end
		shv = (acc_q >> sh) | {105'd0, ((acc_q & ~({106{1'b1}} << sh)) != '0)};
		mant = shv[105:53];
		gbit = shv[52];
		sticky = shv[51:0] != '0;
		rup = gbit && (sticky || mant[0]);
		mr = {1'b0, mant} + {53'd0, rup};
		er = eb0;
		if (mr[53]) begin
			er = eb0 + 14'sd1;
		end
		if (!mr[53] && !mant[52] && !(mr[52])) begin
			packed_r = {sgn_q, 11'd0, mr[51:0]};
		end else if (er >= 14'sd2047) begin
			packed_r = {sgn_q, 11'h7ff, 52'd0};
		end else if (mr[53]) begin
			packed_r = {sgn_q, er[10:0], mr[52:1]};
		end else begin
			packed_r = {sgn_q, er[10:0], mr[51:0]};
		end
	end

	// Sequencer: one shift-add step per cycle for the mantissa product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
			cnt_q <= '0;
		end else begin
			case (st_q)
				F_IDLE: begin
					if (go) begin
						if (is_mul) begin
							st_q <= F_MUL;
						end else begin
							st_q <= F_CVT;
						end
						cnt_q <= '0;
					end
				end
				F_MUL: begin
					if (cnt_q == 6'd52) begin
						st_q <= F_NORM;
					end
					cnt_q <= cnt_q + 6'd1;
				end
				F_NORM: begin
					if (acc_q[105] || acc_q == '0 || spc_q || exp_q < -14'sd60) begin
						st_q <= F_RND;
					end
				end
				F_CVT: st_q <= F_NORM;
				F_RND: st_q <= F_OUT;
				F_OUT: st_q <= F_IDLE;
				default: st_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			F_IDLE: begin
				if (go && is_mul) begin
					sgn_q <= a[63] ^ b[63];
					ma_q <= na; mb_q <= nb; acc_q <= '0;
					exp_q <= xa + xb - 14'sd1023 + 14'sd1;
					spc_q <= a_nan || b_nan || a_inf || b_inf || a_zero || b_zero;
					if (a_nan) spc_val_q <= a | 64'h0008_0000_0000_0000;
					else if (b_nan) spc_val_q <= b | 64'h0008_0000_0000_0000;
					else if ((a_inf && b_zero) || (b_inf && a_zero))
						spc_val_q <= 64'hfff8_0000_0000_0000;
					else if (a_inf || b_inf) spc_val_q <= {a[63] ^ b[63], 11'h7ff, 52'd0};
					else spc_val_q <= {a[63] ^ b[63], 63'd0};
				end else if (go) begin
					sgn_q <= iv[31];
					acc_q <= {imag, 74'd0};
					exp_q <= 14'sd1023 + 14'sd105 - 14'sd105 + 14'sd0;
					spc_q <= (iv == '0);
					spc_val_q <= '0;
				end
			end
			F_MUL: begin
				acc_q <= (acc_q >> 1) + (part << 52);
				mb_q <= mb_q >> 1;
			end
			// The integer's bit 31 sits at bit 105, so the start exponent is bias plus 31.
			F_CVT: exp_q <= 14'sd1023 + 14'sd31;
			F_NORM: begin
				if (!(acc_q[105] || acc_q == '0 || spc_q || exp_q < -14'sd60)) begin
					acc_q <= acc_q << 1;
					exp_q <= exp_q - 14'sd1;
				end
			end
			F_RND: res_q <= spc_q ? spc_val_q : packed_r;
			default: ;
		endcase
	end

	assign done = st_q == F_OUT;
	assign res = res_q;
endmodule
`default_nettype wire

/* hw/rtl/typed_operand_stack_executor.sv */
// Top level: sequencer, stack memory and local file of the operand stack executor.
`default_nettype none
// One bytecode per request; busy is high from acceptance until the result
// strobe. After reset a clearing pass zeroes every slot of the stack memory
// while busy stays high. The single stack memory read port is visited in a
// read and a wait state for each operand slot: one slot for plain bytecodes,
// two for dmul and the compares and three for array store. i2d waits on the
// one-bit-a-step normalising shift and dmul also on the one-bit-a-step
// multiplier of the shared floating-point unit. The result strobe done lasts
// one cycle and cannot be held off by the receiver.
module typed_operand_stack_executor import tose_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);
	typedef enum logic [8:0] {
		S_CLR = 9'b000000001, S_IDLE = 9'b000000010, S_RD = 9'b000000100,
		S_WT = 9'b000001000, S_EXE = 9'b000010000, S_FPU = 9'b000100000,
		S_WB = 9'b001000000, S_RSP = 9'b010000000, S_LOC = 9'b100000000
	} st_t;
	st_t st_q;

	logic [65:0] stk_mem [STACK_DEPTH];
	logic [65:0] rd_q;
	logic [SP_W:0] top_q;   // number of entries on the stack
	logic [SP_W-1:0] clr_q;
	logic [63:0] lval_q [LOCAL_COUNT];
	logic [1:0]  ltag_q [LOCAL_COUNT];
	req_t req_q;
	logic [1:0] rdn_q;     // depth of the slot being read, also the reads left after it
	logic [63:0] s0_q, s1_q, s2_q;
	logic [1:0]  t0_q, t1_q;
	logic [63:0] lv_q;
	logic [1:0]  lt_q;
	rsp_t rsp_q;
	rsp_t rsp_d;
	logic fgo;
	logic [63:0] fres;
	logic fdone;

	logic lok;
	assign lok = {{(8-LI_W){1'b0}}, req_q.local_index[LI_W-1:0]} == 8'(req_q.local_index) ;

	// Address of slot at depth d, clamped to slot 0.
	function automatic logic [SP_W-1:0] slot(input logic [SP_W:0] n, input logic [1:0] d);
		logic [SP_W:0] pos;
		begin
			pos = n - (SP_W+1)'(d) - (SP_W+1)'(1);
			slot = (n > (SP_W+1)'(d)) ? pos[SP_W-1:0] : '0;
		end
	endfunction

	logic is_push;
	logic full;
	logic [SP_W:0] pops;
	logic [SP_W:0] ntop;
	always_comb begin
		is_push = req_q.opcode == OP_IPUSH || req_q.opcode == OP_DPUSH || req_q.opcode == OP_LOAD;
		full = top_q == (SP_W+1)'(STACK_DEPTH);
		case (req_q.opcode)
			OP_STORE, OP_DMUL: pops = (SP_W+1)'(1);
			OP_CMPGE, OP_CMPGT: pops = (SP_W+1)'(2);
			OP_ASTORE: pops = (SP_W+1)'(3);
			default: pops = '0;
		endcase
		ntop = (top_q > pops) ? top_q - pops : '0;
	end

	// Stack memory write port.
	logic we;
	logic [SP_W-1:0] wa;
	logic [65:0] wd;
	always_comb begin
		we = 1'b0; wa = slot(top_q, 2'd0); wd = '0;
		if (st_q == S_CLR) begin
			we = 1'b1; wa = clr_q;
		end else if (st_q == S_WB) begin
			if (is_push) begin
				we = !full; wa = top_q[SP_W-1:0];
				case (req_q.opcode)
					OP_IPUSH: wd = {TAG_INT, 32'd0, req_q.immediate[31:0]};
					OP_DPUSH: wd = {TAG_DBL, req_q.immediate};
					default: wd = lok ? {lt_q, lv_q} : {TAG_INT, 64'd0};
				endcase
			end else if (req_q.opcode == OP_I2D) begin
				we = 1'b1; wd = {TAG_DBL, fres};
			end else if (req_q.opcode == OP_DMUL) begin
				// The new top keeps the tag of the second slot.
				we = 1'b1; wa = slot(ntop, 2'd0); wd = {t1_q, fres};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) stk_mem[wa] <= wd;
		rd_q <= stk_mem[slot(top_q, rdn_q)];
	end

	tose_fpu u_fpu (
		.clk(clk), .arst_n(arst_n), .go(fgo), .is_mul(req_q.opcode == OP_DMUL),
		.a(req_q.opcode == OP_DMUL ? s1_q : s0_q), .b(s0_q), .done(fdone), .res(fres)
	);
	assign fgo = st_q == S_EXE && (req_q.opcode == OP_I2D || req_q.opcode == OP_DMUL);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; clr_q <= '0; top_q <= '0; rdn_q <= '0;
			for (int i = 0; i < LOCAL_COUNT; i++) begin
				lval_q[i] <= '0; ltag_q[i] <= TAG_INT;
			end
		end else begin
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SP_W'(STACK_DEPTH-1)) st_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						st_q <= S_LOC;
						case (req.opcode)
							OP_ASTORE: rdn_q <= 2'd2;
							OP_DMUL, OP_CMPGE, OP_CMPGT: rdn_q <= 2'd1;
							default: rdn_q <= 2'd0;
						endcase
					end
				end
				S_LOC: st_q <= S_RD;
				S_RD: st_q <= S_WT;
				S_WT: begin
					if (rdn_q == 2'd0) st_q <= S_EXE;
					else begin
						rdn_q <= rdn_q - 2'd1; st_q <= S_RD;
					end
				end
				S_EXE: begin
					if (fgo) st_q <= S_FPU;
					else st_q <= S_WB;
				end
				S_FPU: if (fdone) st_q <= S_WB;
				S_WB: begin
					st_q <= S_RSP;
					if (is_push) begin
						if (!full) top_q <= top_q + 1'b1;
					end else top_q <= ntop;
					if (req_q.opcode == OP_STORE && lok) begin
						lval_q[req_q.local_index[LI_W-1:0]] <= s0_q;
						ltag_q[req_q.local_index[LI_W-1:0]] <= t0_q;
					end
					if (req_q.opcode == OP_IINC && lok)
						lval_q[req_q.local_index[LI_W-1:0]][31:0] <= lv_q[31:0] + req_q.immediate[31:0];
				end
				S_RSP: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Result build from the captured operands.
	always_comb begin
		rsp_d = '0;
		rsp_d.stack_fault = is_push && full;
		if (req_q.opcode == OP_ASTORE) begin
			rsp_d.result_kind = KIND_WR;
			rsp_d.write_reference = s2_q;
			rsp_d.write_index = s1_q[31:0];
			rsp_d.write_data = s0_q;
		end else if (req_q.opcode == OP_CMPGE || req_q.opcode == OP_CMPGT) begin
			rsp_d.result_kind = KIND_CMP;
			rsp_d.branch_taken = (req_q.opcode == OP_CMPGE)
				? ($signed(s1_q[31:0]) >= $signed(s0_q[31:0]))
				: ($signed(s1_q[31:0]) > $signed(s0_q[31:0]));
		end
	end

	// Operand capture and result register.
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && start) req_q <= req;
		if (st_q == S_LOC) begin
			lv_q <= lval_q[req_q.local_index[LI_W-1:0]];
			lt_q <= ltag_q[req_q.local_index[LI_W-1:0]];
		end
		if (st_q == S_WT) begin
			case (rdn_q)
				2'd2: s2_q <= rd_q[63:0];
				2'd1: begin
					s1_q <= rd_q[63:0]; t1_q <= rd_q[65:64];
				end
				default: begin
					s0_q <= rd_q[63:0]; t0_q <= rd_q[65:64];
				end
			endcase
		end
		if (st_q == S_WB) rsp_q <= rsp_d;
	end

	assign busy = st_q != S_IDLE;
	assign done = st_q == S_RSP;
	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= (SP_W+1)'(STACK_DEPTH)) else $error("stack count out of range");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_fpu_wait: assert property (@(posedge clk) disable iff (!arst_n)
		fdone |-> st_q == S_FPU) else $error("fpu finished outside wait state");
`endif
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Testbench for the typed operand stack executor: directed, stack-full and random bytecode runs.
`default_nettype none
module tb_top;
	import tose_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] OP_UNUSED_LO = 4'd10;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES = 200;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	typed_operand_stack_executor i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	// Shadow copy of the machine state.
	logic [63:0] stk_val [STACK_DEPTH];
	logic [1:0]  stk_tag [STACK_DEPTH];
	int          stk_top;
	logic [63:0] loc_val [LOCAL_COUNT];
	logic [1:0]  loc_tag [LOCAL_COUNT];

	rsp_t expected_results[$];
	int   mismatches;
	int   requests_sent;
	int   results_seen;
	int   faults_seen;
	bit   idle_on;
	int   quiet_cycles;

	// Clock generation.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic int slot_at(input int depth);
		return (stk_top - depth >= 0) ? stk_top - depth : 0;
	endfunction

	function automatic bit push_slot(input logic [63:0] v, input logic [1:0] t);
		if (stk_top + 1 >= STACK_DEPTH)
			return 1'b1;
		stk_top++;
		stk_val[stk_top] = v;
		stk_tag[stk_top] = t;
		return 1'b0;
	endfunction

	function automatic void pop_slot();
		if (stk_top >= 0)
			stk_top--;
	endfunction

	// Works out the result of one bytecode and updates the shadow state.
	function automatic rsp_t execute_bytecode(input req_t r);
		rsp_t e;
		int s;
		logic signed [31:0] a_i, b_i;
		real a_d, b_d;
		bit in_range;
		e = '0;
		in_range = int'(r.local_index) < LOCAL_COUNT;
		case (r.opcode)
			OP_IPUSH: e.stack_fault = push_slot({32'd0, r.immediate[31:0]}, TAG_INT);
			OP_DPUSH: e.stack_fault = push_slot(r.immediate, TAG_DBL);
			OP_LOAD: begin
				if (in_range)
					e.stack_fault = push_slot(loc_val[r.local_index], loc_tag[r.local_index]);
				else
					e.stack_fault = push_slot(64'd0, TAG_INT);
			end
			OP_STORE: begin
				s = slot_at(0);
				if (in_range) begin
					loc_val[r.local_index] = stk_val[s];
					loc_tag[r.local_index] = stk_tag[s];
				end
				pop_slot();
			end
			OP_I2D: begin
				s = slot_at(0);
				a_i = stk_val[s][31:0];
				stk_val[s] = $realtobits($itor(a_i));
				stk_tag[s] = TAG_DBL;
			end
			OP_DMUL: begin
				a_d = $bitstoreal(stk_val[slot_at(1)]);
				b_d = $bitstoreal(stk_val[slot_at(0)]);
				pop_slot();
				stk_val[slot_at(0)] = $realtobits(a_d * b_d);
			end
			OP_IINC: begin
				if (in_range)
					loc_val[r.local_index][31:0] =
						loc_val[r.local_index][31:0] + r.immediate[31:0];
			end
			OP_ASTORE: begin
				e.write_reference = stk_val[slot_at(2)];
				e.write_index = stk_val[slot_at(1)][31:0];
				e.write_data = stk_val[slot_at(0)];
				pop_slot();
				pop_slot();
				pop_slot();
				e.result_kind = KIND_WR;
			end
			OP_CMPGE, OP_CMPGT: begin
				a_i = stk_val[slot_at(1)][31:0];
				b_i = stk_val[slot_at(0)][31:0];
				pop_slot();
				pop_slot();
				e.branch_taken = (r.opcode == OP_CMPGE) ? (a_i >= b_i) : (a_i > b_i);
				e.result_kind = KIND_CMP;
			end
			default: e.result_kind = KIND_DONE;
		endcase
		return e;
	endfunction

	// Sends one request, waits for acceptance and records its expected result.
	task automatic send_request(input logic [3:0] op, input logic [4:0] idx,
			input logic [63:0] imm);
		req_t r;
		r.opcode = op;
		r.local_index = idx;
		r.immediate = imm;
		if (idle_on && $urandom_range(99) < 15)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		@(negedge clk);
		start = 1'b1;
		req = r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_results.push_back(execute_bytecode(r));
		requests_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic wait_until_drained();
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Result checker: each strobe is compared with the oldest expectation.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && done) begin
			results_seen++;
			if (rsp.stack_fault)
				faults_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", rsp);
			end else begin
				e = expected_results.pop_front();
				if (rsp.result_kind !== e.result_kind || rsp.branch_taken !== e.branch_taken
						|| rsp.write_reference !== e.write_reference
						|| rsp.write_index !== e.write_index
						|| rsp.write_data !== e.write_data
						|| rsp.stack_fault !== e.stack_fault) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d mismatch: expected %p, got %p",
							results_seen, e, rsp);
				end
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [63:0] random_double();
		case ($urandom_range(7))
			0: return 64'h0000_0000_0000_0000;
			1: return 64'h8000_0000_0000_0000;
			2: return 64'h3FF0_0000_0000_0000;
			3: return $realtobits($itor($signed($urandom_range(2000))) - 1000.0);
			4: return {1'b0, 11'h7FF, 52'd0};
			5: return {$urandom(), $urandom()} & 64'h800F_FFFF_FFFF_FFFF;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic logic [63:0] random_wide();
		return {$urandom(), $urandom()};
	endfunction

	// Extremes of the fields, every opcode and the edge cases on an empty stack.
	task automatic test_directed();
		send_request(OP_STORE, 5'd0, 64'd0);
		send_request(OP_I2D, 5'd1, 64'd0);
		send_request(OP_DMUL, 5'd2, 64'd0);
		send_request(OP_ASTORE, 5'd3, 64'd0);
		send_request(OP_CMPGE, 5'd4, 64'd0);
		send_request(OP_IPUSH, 5'd31, 64'hFFFF_FFFF_8000_0000);
		send_request(OP_IPUSH, 5'd0, 64'h0000_0000_7FFF_FFFF);
		send_request(OP_CMPGT, 5'd0, 64'd0);
		send_request(OP_IPUSH, 5'd0, 64'h0000_0000_7FFF_FFFF);
		send_request(OP_IPUSH, 5'd0, 64'h0000_0000_7FFF_FFFF);
		send_request(OP_CMPGE, 5'd0, 64'd0);
		send_request(OP_DPUSH, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(OP_STORE, 5'd31, 64'd0);
		send_request(OP_IINC, 5'd31, 64'h0000_0000_0000_0001);
		send_request(OP_IINC, 5'd7, 64'hAAAA_AAAA_8000_0000);
		send_request(OP_LOAD, 5'd31, 64'd0);
		send_request(OP_LOAD, 5'd7, 64'd0);
		send_request(OP_I2D, 5'd0, 64'd0);
		send_request(OP_DPUSH, 5'd0, 64'h4000_0000_0000_0000);
		send_request(OP_DMUL, 5'd0, 64'd0);
		send_request(OP_ASTORE, 5'd0, 64'd0);
		send_request(OP_UNUSED_LO, 5'd0, 64'd0);
		send_request(OP_UNUSED_HI, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
		wait_until_drained();
	endtask

	// Fills the stack back to back, pushes past the top, then drains it and pops beyond empty.
	task automatic test_stack_full();
		idle_on = 1'b0;
		while (stk_top < STACK_DEPTH - 1)
			send_request(OP_IPUSH, 5'($urandom_range(31)), random_wide());
		idle_on = 1'b1;
		send_request(OP_IPUSH, 5'd0, 64'd1);
		send_request(OP_DPUSH, 5'd0, 64'd2);
		send_request(OP_LOAD, 5'd3, 64'd0);
		send_request(OP_CMPGT, 5'd0, 64'd0);
		send_request(OP_LOAD, 5'd3, 64'd0);
		send_request(OP_LOAD, 5'd3, 64'd0);
		while (stk_top >= 2)
			send_request(OP_ASTORE, 5'($urandom_range(31)), 64'd0);
		while (stk_top >= 0)
			send_request(OP_STORE, 5'($urandom_range(31)), 64'd0);
		send_request(OP_STORE, 5'd0, 64'd0);
		wait_until_drained();
	endtask

	// Random bytecode sequences, mostly well-formed, with a stretch without gaps.
	task automatic test_random(input int count);
		int n;
		n = 0;
		while (n < count) begin
			idle_on = !(n > count / 3 && n < count / 2);
			if (n == count / 4)
				wait_until_drained();
			case ($urandom_range(9))
				0, 1: begin
					send_request(OP_DPUSH, 5'($urandom), random_wide());
					send_request(OP_IPUSH, 5'($urandom), random_wide());
					send_request(OP_DPUSH, 5'($urandom), random_double());
					send_request(OP_ASTORE, 5'($urandom), random_wide());
					n += 4;
				end
				2, 3: begin
					send_request(OP_IPUSH, 5'($urandom), random_wide());
					send_request(OP_I2D, 5'($urandom), random_wide());
					send_request(OP_DPUSH, 5'($urandom), random_double());
					send_request(OP_DMUL, 5'($urandom), random_wide());
					send_request(OP_STORE, 5'($urandom), random_wide());
					n += 5;
				end
				4, 5: begin
					send_request(OP_IPUSH, 5'($urandom), random_wide());
					if ($urandom_range(1))
						send_request(OP_LOAD, 5'($urandom), random_wide());
					else
						send_request(OP_IPUSH, 5'($urandom), random_wide());
					send_request(4'($urandom_range(OP_CMPGE, OP_CMPGT)), 5'($urandom),
						random_wide());
					n += 3;
				end
				6: begin
					send_request(OP_IINC, 5'($urandom), random_wide());
					send_request(OP_LOAD, 5'($urandom), random_wide());
					n += 2;
				end
				default: begin
					if (stk_top > 40)
						send_request(OP_STORE, 5'($urandom), random_wide());
					else
						send_request(4'($urandom), 5'($urandom), random_wide());
					n += 1;
				end
			endcase
		end
		idle_on = 1'b1;
	endtask

	initial begin
		int tail;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		idle_on = 1'b1;
		mismatches = 0;
		requests_sent = 0;
		results_seen = 0;
		faults_seen = 0;
		quiet_cycles = 0;
		stk_top = -1;
		foreach (stk_val[i]) begin
			stk_val[i] = '0;
			stk_tag[i] = TAG_INT;
		end
		foreach (loc_val[i]) begin
			loc_val[i] = '0;
			loc_tag[i] = TAG_INT;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_stack_full();
		test_random(100);

		wait_until_drained();
		tail = 0;
		while (tail < TAIL_CYCLES) begin
			@(posedge clk);
			tail++;
		end
		$display("Ran %0d bytecodes, %0d results checked, %0d overflow faults seen.",
			requests_sent, results_seen, faults_seen);
		$display("Mismatches: %0d.", mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
